/* rtl/core/ifis_pkg.sv */
// ifis_pkg: shared types, codes and constants of the flash image sequencer.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps
`default_nettype none

package ifis_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int CFG_IDX_W = 3;

    // command queue between parser and emitter
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_VERIFY_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_MASK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_OPCODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_READ_OPCODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PW_OPCODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HI_SEL_MASK  = 3'd5;

    // reset values of the configuration registers
    localparam logic [WORD_W-1:0] RST_PAGE_MASK   = 16'd63;
    localparam logic [BYTE_W-1:0] RST_LOAD_OPCODE = 8'd64;
    localparam logic [BYTE_W-1:0] RST_READ_OPCODE = 8'd32;
    localparam logic [BYTE_W-1:0] RST_PW_OPCODE   = 8'd76;
    localparam logic [BYTE_W-1:0] RST_HI_SEL_MASK = 8'd8;

    typedef enum logic [1:0] {
        KIND_LOAD       = 2'd0,
        KIND_PAGE_WRITE = 2'd1,
        KIND_READ       = 2'd2,
        KIND_END        = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_CNT_LO = 3'd0,
        PH_CNT_HI = 3'd1,
        PH_ADR_LO = 3'd2,
        PH_ADR_HI = 3'd3,
        PH_DATA   = 3'd4
    } t_phase;

    typedef struct packed {
        logic              verify_mode;
        logic [WORD_W-1:0] page_mask;
        logic [BYTE_W-1:0] load_opcode;
        logic [BYTE_W-1:0] read_opcode;
        logic [BYTE_W-1:0] pw_opcode;
        logic [BYTE_W-1:0] hi_sel_mask;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] command_byte;
        logic [WORD_W-1:0] word_address;
        logic [BYTE_W-1:0] payload_byte;
        logic              poll_after;
        logic              last;
    } t_result;

    // everything one image byte produces
    typedef struct packed {
        t_result first;
        t_result second;
        logic    has_second;
    } t_qentry;

endpackage

`default_nettype wire

/* rtl/core/ifis_front.sv */
// ifis_front: image byte parser; classifies bytes and builds command entries.
// Depends on ifis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ifis_front
    import ifis_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [BYTE_W-1:0] i_image_byte,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_qentry                o_entry
);

    t_phase            r_phase, n_phase;
    logic [WORD_W-1:0] r_words, n_words;
    logic [WORD_W-1:0] r_addr, n_addr;
    logic [BYTE_W-1:0] r_held, n_held;
    logic              r_hi, n_hi;

    logic              accept;
    logic              has_out;
    logic [WORD_W-1:0] cnt;
    logic [WORD_W-1:0] addr_inc;
    logic [BYTE_W-1:0] sel;
    logic              full_pg;
    logic              part_pg;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && has_out;

    assign cnt      = {i_image_byte, r_words[BYTE_W-1:0]};
    assign addr_inc = r_addr + 16'd1;
    assign sel      = r_hi ? i_cfg.hi_sel_mask : '0;
    assign full_pg  = !i_cfg.verify_mode && r_hi
                      && ((r_addr & i_cfg.page_mask) == i_cfg.page_mask);
    assign part_pg  = !i_cfg.verify_mode && !full_pg && (r_words == 16'd1)
                      && ((addr_inc & i_cfg.page_mask) != '0);

    always_comb begin
        n_phase = r_phase;
        n_words = r_words;
        n_addr  = r_addr;
        n_held  = r_held;
        n_hi    = r_hi;
        has_out = 1'b0;
        o_entry = '0;
        unique case (r_phase)
            PH_CNT_HI: begin
                n_words = cnt;
                if (cnt == '0) begin
                    has_out             = 1'b1;
                    o_entry.first.kind  = KIND_END;
                    o_entry.first.last  = 1'b1;
                    n_phase             = PH_CNT_LO;
                end else begin
                    n_phase = PH_ADR_LO;
                end
            end
            PH_ADR_LO: begin
                n_held  = i_image_byte;
                n_phase = PH_ADR_HI;
            end
            PH_ADR_HI: begin
                n_addr  = {i_image_byte, r_held};
                n_hi    = 1'b0;
                n_phase = PH_DATA;
            end
            PH_DATA: begin
                has_out                    = 1'b1;
                o_entry.first.word_address = r_addr;
                o_entry.first.payload_byte = i_image_byte;
                if (i_cfg.verify_mode) begin
                    o_entry.first.kind         = KIND_READ;
                    o_entry.first.command_byte = i_cfg.read_opcode ^ sel;
                end else begin
                    o_entry.first.kind         = KIND_LOAD;
                    o_entry.first.command_byte = i_cfg.load_opcode ^ sel;
                end
                o_entry.second.kind         = KIND_PAGE_WRITE;
                o_entry.second.command_byte = i_cfg.pw_opcode;
                // full page writes at the word just loaded, partial at the next one
                o_entry.second.word_address = full_pg ? r_addr : addr_inc;
                o_entry.second.poll_after   = 1'b1;
                o_entry.second.last         = 1'b1;
                if (r_hi) begin
                    n_hi               = 1'b0;
                    n_addr             = addr_inc;
                    n_words            = r_words - 16'd1;
                    o_entry.has_second = full_pg || part_pg;
                    if (r_words == 16'd1) begin
                        n_phase = PH_CNT_LO;
                    end
                end else begin
                    n_hi = 1'b1;
                end
                o_entry.first.last = !o_entry.has_second;
            end
            default: begin
                // count low byte, also any stray phase code
                n_words = {{(WORD_W-BYTE_W){1'b0}}, i_image_byte};
                n_phase = PH_CNT_HI;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CNT_LO;
            r_words <= '0;
            r_addr  <= '0;
            r_held  <= '0;
            r_hi    <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_words <= n_words;
            r_addr  <= n_addr;
            r_held  <= n_held;
            r_hi    <= n_hi;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ifis_queue.sv */
// ifis_queue: short flop-based FIFO of command entries between parser and emitter.
// Depends on ifis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ifis_queue
    import ifis_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_qentry i_entry,
    input  wire logic    i_pop,
    output t_qentry      o_entry,
    output logic         o_full,
    output logic         o_empty
);

    t_qentry             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("ifis_queue: count above depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("ifis_queue: pop from empty queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("ifis_queue: push lost");

endmodule

`default_nettype wire

/* rtl/core/ifis_back.sv */
// ifis_back: emitter; pops command entries and issues one result per cycle while the receiver does not stall.
// Depends on ifis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ifis_back
    import ifis_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_qentry i_entry,
    input  wire logic    i_q_empty,
    output logic         o_pop,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_result      o_result
);

    logic    r_out_valid;
    logic    r_pend;
    t_result r_out;
    t_result r_second;
    logic    load;

    assign load        = !r_out_valid || i_out_ready;
    assign o_pop       = load && !r_pend && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else begin
                r_out_valid <= !i_q_empty;
                r_pend      <= !i_q_empty && i_entry.has_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_out <= r_second;
            end else if (!i_q_empty) begin
                r_out    <= i_entry.first;
                r_second <= i_entry.second;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/isp_flash_image_sequencer_core.sv */
// Flash image sequencer for serial page programming, top level.
// Input channel: one image byte per transaction (valid/ready). Output channel:
// one 36-bit command descriptor per transaction (kind, command byte, word
// address, payload byte, poll flag, last marker).
// Configuration: plain write port, i_cfg_we with index and data; write only
// while the block is idle.
// Path: the parser pushes the entry of an accepted byte into the command
// queue, and the emitter then loads it into the output register.
// Throughput: one byte per cycle while the receiver does not stall, when each
// byte gives at most one result; a byte that also triggers a page write gives
// two results, since the emitter issues one result per cycle. Address bytes
// and a nonzero count give no result; a zero count gives an end result.
// When the receiver stalls the output register holds, the two-entry command
// queue fills and then o_in_ready drops; nothing is lost.
// Reset (synchronous, active low) restores the register defaults, empties
// the queue and output register, and restarts parsing at a count low byte.
`timescale 1ns / 1ps
`default_nettype none

module isp_flash_image_sequencer_core
    import ifis_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [WORD_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [BYTE_W-1:0]    i_image_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_kind,
    output logic [BYTE_W-1:0]         o_command_byte,
    output logic [WORD_W-1:0]         o_word_address,
    output logic [BYTE_W-1:0]         o_payload_byte,
    output logic                      o_poll_after,
    output logic                      o_last
);

    t_cfg    r_cfg;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    t_qentry q_wr_entry;
    t_qentry q_rd_entry;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.verify_mode <= 1'b0;
            r_cfg.page_mask   <= RST_PAGE_MASK;
            r_cfg.load_opcode <= RST_LOAD_OPCODE;
            r_cfg.read_opcode <= RST_READ_OPCODE;
            r_cfg.pw_opcode   <= RST_PW_OPCODE;
            r_cfg.hi_sel_mask <= RST_HI_SEL_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VERIFY_MODE: r_cfg.verify_mode <= i_cfg_data[0];
                REG_PAGE_MASK:   r_cfg.page_mask   <= i_cfg_data;
                REG_LOAD_OPCODE: r_cfg.load_opcode <= i_cfg_data[BYTE_W-1:0];
                REG_READ_OPCODE: r_cfg.read_opcode <= i_cfg_data[BYTE_W-1:0];
                REG_PW_OPCODE:   r_cfg.pw_opcode   <= i_cfg_data[BYTE_W-1:0];
                REG_HI_SEL_MASK: r_cfg.hi_sel_mask <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    ifis_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_image_byte (i_image_byte),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_entry      (q_wr_entry)
    );

    ifis_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .i_pop   (q_pop),
        .o_entry (q_rd_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ifis_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (q_rd_entry),
        .i_q_empty   (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_kind         = result.kind;
    assign o_command_byte = result.command_byte;
    assign o_word_address = result.word_address;
    assign o_payload_byte = result.payload_byte;
    assign o_poll_after   = result.poll_after;
    assign o_last         = result.last;

endmodule

`default_nettype wire

/* tb/isp_flash_image_sequencer_core_test.sv */
// Self-checking testbench for isp_flash_image_sequencer_core: directed and random images,
// random stalls on both channels, predicted commands compared field by field.
// Depends on ifis_pkg and the core RTL only.
`timescale 1ns / 1ps

module isp_flash_image_sequencer_core_test;
    import ifis_pkg::*;

    localparam int QUIET_LIMIT  = 2000;  // cycles without any transaction
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 4;     // settle margin after the last expected command
    localparam int TAIL_CYCLES  = 10;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx    = '0;
    logic [WORD_W-1:0]    cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    image_byte = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    logic [1:0]           kind;
    logic [BYTE_W-1:0]    command_byte;
    logic [WORD_W-1:0]    word_address;
    logic [BYTE_W-1:0]    payload_byte;
    logic                 poll_after;
    logic                 last;

    // stimulus side
    logic [BYTE_W-1:0] image_bytes_q [$];
    bit                idle_on  = 1'b1;
    bit                hold_req = 1'b0;
    int                send_gap = 0;
    int                rx_gap   = 0;
    int                hold_cnt = 0;
    bit                hold_done = 1'b0;

    // predictor state: register copy and parser state
    t_cfg              cfg_shadow;
    t_phase            parse_st;
    logic [WORD_W-1:0] words_left;
    logic [WORD_W-1:0] word_addr;
    logic [BYTE_W-1:0] addr_lo;
    logic              hi_phase;
    t_result           expected_cmds [$];
    int                mismatches = 0;
    int                quiet = 0;

    isp_flash_image_sequencer_core u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_image_byte   (image_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_kind         (kind),
        .o_command_byte (command_byte),
        .o_word_address (word_address),
        .o_payload_byte (payload_byte),
        .o_poll_after   (poll_after),
        .o_last         (last)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic t_result make_cmd(t_kind k, logic [BYTE_W-1:0] opc,
                                         logic [WORD_W-1:0] addr,
                                         logic [BYTE_W-1:0] pay, logic poll);
        t_result r;
        r.kind         = k;
        r.command_byte = opc;
        r.word_address = addr;
        r.payload_byte = pay;
        r.poll_after   = poll;
        r.last         = 1'b0;
        return r;
    endfunction

    // Advance the parser by one image byte and queue the commands it yields.
    task automatic sequence_image_byte(input logic [BYTE_W-1:0] b);
        t_result           first_cmd;
        t_result           second_cmd;
        int                n;
        logic              full_pw;
        logic [BYTE_W-1:0] sel;
        n       = 0;
        full_pw = 1'b0;
        case (parse_st)
            PH_CNT_HI: begin
                words_left = {b, words_left[BYTE_W-1:0]};
                if (words_left == '0) begin
                    first_cmd = make_cmd(KIND_END, '0, '0, '0, 1'b0);
                    n = 1;
                    parse_st = PH_CNT_LO;
                end else begin
                    parse_st = PH_ADR_LO;
                end
            end
            PH_ADR_LO: begin
                addr_lo  = b;
                parse_st = PH_ADR_HI;
            end
            PH_ADR_HI: begin
                word_addr = {b, addr_lo};
                hi_phase  = 1'b0;
                parse_st  = PH_DATA;
            end
            PH_DATA: begin
                sel = hi_phase ? cfg_shadow.hi_sel_mask : '0;
                n = 1;
                if (cfg_shadow.verify_mode) begin
                    first_cmd = make_cmd(KIND_READ, cfg_shadow.read_opcode ^ sel,
                                         word_addr, b, 1'b0);
                end else begin
                    first_cmd = make_cmd(KIND_LOAD, cfg_shadow.load_opcode ^ sel,
                                         word_addr, b, 1'b0);
                    if (hi_phase &&
                        (word_addr & cfg_shadow.page_mask) == cfg_shadow.page_mask) begin
                        second_cmd = make_cmd(KIND_PAGE_WRITE, cfg_shadow.pw_opcode,
                                              word_addr, '0, 1'b1);
                        n = 2;
                        full_pw = 1'b1;
                    end
                end
                if (hi_phase) begin
                    hi_phase   = 1'b0;
                    word_addr  = word_addr + 1'b1;
                    words_left = words_left - 1'b1;
                    if (words_left == '0) begin
                        parse_st = PH_CNT_LO;
                        // block ended inside a page; a full-page write wins
                        if (!cfg_shadow.verify_mode && !full_pw &&
                            (word_addr & cfg_shadow.page_mask) != '0) begin
                            second_cmd = make_cmd(KIND_PAGE_WRITE, cfg_shadow.pw_opcode,
                                                  word_addr, '0, 1'b1);
                            n = 2;
                        end
                    end
                end else begin
                    hi_phase = 1'b1;
                end
            end
            default: begin
                words_left = {8'h00, b};
                parse_st   = PH_CNT_HI;
            end
        endcase
        if (n == 1) begin
            first_cmd.last = 1'b1;
            expected_cmds.push_back(first_cmd);
        end else if (n == 2) begin
            second_cmd.last = 1'b1;
            expected_cmds.push_back(first_cmd);
            expected_cmds.push_back(second_cmd);
        end
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // driver: feeds image bytes from the queue, with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || in_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (image_bytes_q.size() > 0) begin
                in_valid   <= 1'b1;
                image_byte <= image_bytes_q.pop_front();
                if (idle_on && $urandom_range(0, 11) == 0)
                    send_gap <= $urandom_range(1, 19);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_gap    <= 0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt  <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap    <= rx_gap - 1;
            out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rx_gap    <= $urandom_range(0, 18);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // monitor: register copy, prediction on input, comparison on output
    always @(posedge clk) begin : monitor
        t_result want;
        if (!rst_n) begin
            cfg_shadow.verify_mode = 1'b0;
            cfg_shadow.page_mask   = RST_PAGE_MASK;
            cfg_shadow.load_opcode = RST_LOAD_OPCODE;
            cfg_shadow.read_opcode = RST_READ_OPCODE;
            cfg_shadow.pw_opcode   = RST_PW_OPCODE;
            cfg_shadow.hi_sel_mask = RST_HI_SEL_MASK;
            parse_st   = PH_CNT_LO;
            words_left = '0;
            word_addr  = '0;
            addr_lo    = '0;
            hi_phase   = 1'b0;
            expected_cmds.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (expected_cmds.size() == 0) begin
                    $error("command with nothing expected: kind %0d, address 0x%0h",
                           kind, word_address);
                    mismatches++;
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("kind", 32'(want.kind), 32'(kind));
                    check_field("command_byte", 32'(want.command_byte), 32'(command_byte));
                    check_field("word_address", 32'(want.word_address), 32'(word_address));
                    check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
                    check_field("poll_after", 32'(want.poll_after), 32'(poll_after));
                    check_field("last", 32'(want.last), 32'(last));
                end
            end
            if (cfg_we) begin
                case (cfg_idx)
                    REG_VERIFY_MODE: cfg_shadow.verify_mode = cfg_data[0];
                    REG_PAGE_MASK:   cfg_shadow.page_mask   = cfg_data;
                    REG_LOAD_OPCODE: cfg_shadow.load_opcode = cfg_data[BYTE_W-1:0];
                    REG_READ_OPCODE: cfg_shadow.read_opcode = cfg_data[BYTE_W-1:0];
                    REG_PW_OPCODE:   cfg_shadow.pw_opcode   = cfg_data[BYTE_W-1:0];
                    REG_HI_SEL_MASK: cfg_shadow.hi_sel_mask = cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                sequence_image_byte(image_byte);
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
    endtask

    task automatic apply_setup(input t_cfg c);
        write_reg(REG_VERIFY_MODE, {15'd0, c.verify_mode});
        write_reg(REG_PAGE_MASK, c.page_mask);
        write_reg(REG_LOAD_OPCODE, {8'd0, c.load_opcode});
        write_reg(REG_READ_OPCODE, {8'd0, c.read_opcode});
        write_reg(REG_PW_OPCODE, {8'd0, c.pw_opcode});
        write_reg(REG_HI_SEL_MASK, {8'd0, c.hi_sel_mask});
        // writes to unused indexes must be ignored
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                      WORD_W'($urandom_range(0, 65535)));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (image_bytes_q.size() != 0 || in_valid || expected_cmds.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_header(input logic [WORD_W-1:0] words, input logic [WORD_W-1:0] addr);
        image_bytes_q.push_back(words[7:0]);
        image_bytes_q.push_back(words[15:8]);
        image_bytes_q.push_back(addr[7:0]);
        image_bytes_q.push_back(addr[15:8]);
    endtask

    task automatic queue_block(input int words, input logic [WORD_W-1:0] addr);
        queue_header(words[WORD_W-1:0], addr);
        repeat (2 * words) image_bytes_q.push_back(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic queue_end();
        image_bytes_q.push_back(8'h00);
        image_bytes_q.push_back(8'h00);
    endtask

    // Well-formed blocks and end markers, addresses often near a page end.
    task automatic queue_random_image(input int target, input logic [WORD_W-1:0] mask);
        int                added;
        int                words;
        int                pick;
        logic [WORD_W-1:0] addr;
        added = 0;
        while (added < target) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_end();
                added += 2;
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    words = $urandom_range(1, 4);
                else if (pick < 19)
                    words = $urandom_range(5, 16);
                else
                    words = $urandom_range(17, 40);
                if ($urandom_range(0, 1))
                    addr = (WORD_W'($urandom) & ~mask)
                           | ((mask - WORD_W'($urandom_range(0, 3))) & mask);
                else
                    addr = WORD_W'($urandom_range(0, 65535));
                queue_block(words, addr);
                added += 4 + 2 * words;
            end
        end
    endtask

    function automatic t_cfg random_setup(input int p);
        t_cfg c;
        c.verify_mode = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 6))
            0: c.page_mask = 16'h0000;
            1: c.page_mask = 16'hFFFF;
            2: c.page_mask = 16'd63;
            3: c.page_mask = 16'd15;
            4: c.page_mask = 16'd3;
            5: c.page_mask = 16'd1;
            default: c.page_mask = WORD_W'($urandom_range(0, 65535));
        endcase
        c.load_opcode = BYTE_W'($urandom_range(0, 255));
        c.read_opcode = BYTE_W'($urandom_range(0, 255));
        c.pw_opcode   = BYTE_W'($urandom_range(0, 255));
        c.hi_sel_mask = BYTE_W'($urandom_range(0, 255));
        if (p == 0) begin
            c = '0;
        end else if (p == 1 || p == 2) begin
            c = '1;
            c.verify_mode = (p == 2);
        end
        return c;
    endfunction

    initial begin : stimulus
        t_cfg setup;
        int   p;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: empty image, wrap across 0xFFFF, partial page
        queue_end();
        queue_header(16'd2, 16'hFFFF);
        image_bytes_q.push_back(8'h00);
        image_bytes_q.push_back(8'hFF);
        image_bytes_q.push_back(8'h55);
        image_bytes_q.push_back(8'hAA);
        queue_header(16'd1, 16'h0100);
        image_bytes_q.push_back(8'hA5);
        image_bytes_q.push_back(8'h5A);
        wait_idle();

        // switch to verify halfway through a block
        queue_header(16'd2, 16'h0010);
        image_bytes_q.push_back(8'h01);
        image_bytes_q.push_back(8'h80);
        wait_idle();
        setup = '{verify_mode: 1'b1, page_mask: RST_PAGE_MASK, load_opcode: RST_LOAD_OPCODE,
                  read_opcode: RST_READ_OPCODE, pw_opcode: RST_PW_OPCODE,
                  hi_sel_mask: RST_HI_SEL_MASK};
        apply_setup(setup);
        image_bytes_q.push_back(8'h7F);
        image_bytes_q.push_back(8'hFE);
        wait_idle();

        // non-contiguous mask: full and partial conditions on the same byte, full wins
        setup = '{verify_mode: 1'b0, page_mask: 16'h0005, load_opcode: 8'hFF,
                  read_opcode: 8'h00, pw_opcode: 8'h00, hi_sel_mask: 8'hFF};
        apply_setup(setup);
        queue_header(16'd1, 16'h0005);
        image_bytes_q.push_back(8'h3C);
        image_bytes_q.push_back(8'hC3);
        wait_idle();

        // one long block (count high byte set) under a long receiver hold-off
        setup = random_setup(3);
        setup.verify_mode = 1'b0;
        setup.page_mask   = 16'd15;
        apply_setup(setup);
        queue_block(256, WORD_W'($urandom_range(0, 65535)));
        queue_end();
        hold_req = 1'b1;
        wait_idle();

        for (p = 0; p < 11; p++) begin
            if (p >= 9)
                idle_on = 1'b0;
            setup = random_setup(p);
            apply_setup(setup);
            queue_random_image(70, setup.page_mask);
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
